### hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants for the telemetry frame deframer: frame sizes,
// result status codes and the word RAM port structs.
// ----------------------------------------------------------------------------
package tfd_pkg;

  // frame geometry: mode byte plus twelve 16-bit words
  localparam int unsigned PAYLOAD_BYTES = 25;
  localparam int unsigned NUM_WORDS     = (PAYLOAD_BYTES + 1) / 2;
  localparam int unsigned WORD_AW       = $clog2(NUM_WORDS);
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES + 1);

  // expected length byte and default sync word
  localparam logic [7:0]  LEN_BYTE   = 8'(PAYLOAD_BYTES);
  localparam logic [15:0] SYNC_RESET = 16'hEFFE;

  // index of the final word of a good frame
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

  // result status codes
  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_t;

  // word RAM write port
  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
    logic [15:0]        data;
  } ram_wr_t;

  // word RAM read request
  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
  } ram_rd_t;

endpackage

### hdl/tfd_word_ram.sv
// ----------------------------------------------------------------------------
// tfd_word_ram
// Payload word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tfd_word_ram (
  input  logic                         clk,
  input  tfd_pkg::ram_wr_t             wr,
  input  tfd_pkg::ram_rd_t             rd,
  output logic [15:0]                  rd_data
);

  logic [15:0] mem [tfd_pkg::NUM_WORDS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### hdl/telemetry_frame_deframer.sv
// ----------------------------------------------------------------------------
// telemetry_frame_deframer
// Hunts a two-byte sync word in a byte stream, checks the length byte and
// the checksum, stores the payload as words in a RAM and plays a good frame
// back as thirteen field items.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_rx_byte
//  out_    | output    | out_valid/out_stall | field_index, field_value, status, last
//  cfg_    | input     | cfg_wr_en           | cfg_sync_word
//
//  Header, length and payload bytes are taken one per cycle while the output register is free.
//  A bad length or checksum byte loads one error item into the output
//  register; the next byte is held off only while that item is stalled.
//  A good checksum starts playback: one RAM read per field, with one read
//  in flight at a time; no byte is taken then.
//  Reset (rst_n low, synchronous) returns to sync hunting and restores the
//  default sync word; the payload RAM is not cleared.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_sync_word,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // field output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_field_index,
  output logic [15:0] out_field_value,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int unsigned AW = tfd_pkg::WORD_AW;
  localparam int unsigned CW = tfd_pkg::CNT_W;

  typedef enum logic [2:0] {
    PH_SYNC_HI  = 3'd0,
    PH_SYNC_LO  = 3'd1,
    PH_LENGTH   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECK    = 3'd4,
    PH_PLAYBACK = 3'd5
  } phase_t;

  phase_t              phase_r;
  logic [15:0]         sync_r;
  logic [CW-1:0]       cnt_r;
  logic [7:0]          sum_r;
  logic [7:0]          lo_byte_r;
  logic [AW:0]         rd_idx_r;     // next word to read, reaches NUM_WORDS
  logic                rd_pend_r;
  logic [AW-1:0]       pend_idx_r;
  logic                out_valid_r;
  logic [AW-1:0]       out_idx_r;
  logic [15:0]         out_value_r;
  tfd_pkg::status_t    out_status_r;
  logic                out_last_r;

  logic                in_take;
  logic                out_free;
  logic [7:0]          sum_nxt;
  logic [CW-1:0]       cnt_nxt;
  logic                rd_issue;
  logic                len_bad;
  logic                sum_bad;
  logic                out_load;
  tfd_pkg::ram_wr_t    ram_wr;
  tfd_pkg::ram_rd_t    ram_rd;
  logic [15:0]         ram_q;

  // output register is free this edge when empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (phase_r == PH_PLAYBACK) || !out_free;
  assign in_take  = in_valid && !in_stall;

  assign sum_nxt = sum_r + in_rx_byte;
  assign cnt_nxt = cnt_r + CW'(1);

  // frame checks and output register load
  assign len_bad  = (in_rx_byte != tfd_pkg::LEN_BYTE);
  assign sum_bad  = (8'(-sum_r) != in_rx_byte);
  assign out_load = (in_take && phase_r == PH_LENGTH && len_bad) ||
                    (in_take && phase_r == PH_CHECK && sum_bad) ||
                    (phase_r == PH_PLAYBACK && rd_pend_r);

  // payload writes: mode byte alone, then a word on each high byte
  always_comb begin
    ram_wr.en   = 1'b0;
    ram_wr.addr = cnt_r[AW:1];
    ram_wr.data = {in_rx_byte, lo_byte_r};
    if (in_take && phase_r == PH_PAYLOAD) begin
      if (cnt_r == '0) begin
        ram_wr.en   = 1'b1;
        ram_wr.data = {8'h00, in_rx_byte};
      end else if (!cnt_r[0]) begin
        ram_wr.en = 1'b1;
      end
    end
  end

  // playback reads: one in flight, issued when the output slot will be free;
  // writes and reads never overlap since input is held off during playback
  assign rd_issue = (phase_r == PH_PLAYBACK) && !rd_pend_r &&
                    (rd_idx_r != (AW + 1)'(tfd_pkg::NUM_WORDS)) && out_free;
  assign ram_rd.en   = rd_issue;
  assign ram_rd.addr = rd_idx_r[AW-1:0];

  tfd_word_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_q)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= tfd_pkg::SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_r <= cfg_sync_word;
    end
  end

  // frame state machine and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC_HI;
      cnt_r       <= '0;
      sum_r       <= '0;
      rd_pend_r   <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output slot fills on a new item, else drains when taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (phase_r)
        PH_SYNC_LO: begin
          if (in_take) begin
            phase_r <= (in_rx_byte == sync_r[7:0]) ? PH_LENGTH : PH_SYNC_HI;
          end
        end
        PH_LENGTH: begin
          if (in_take) begin
            if (len_bad) begin
              phase_r      <= PH_SYNC_HI;
              out_idx_r    <= '0;
              out_value_r  <= '0;
              out_status_r <= tfd_pkg::ST_BAD_LEN;
              out_last_r   <= 1'b1;
            end else begin
              sum_r   <= in_rx_byte;
              cnt_r   <= '0;
              phase_r <= PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (in_take) begin
            sum_r <= sum_nxt;
            cnt_r <= cnt_nxt;
            if (cnt_r[0]) begin
              lo_byte_r <= in_rx_byte;
            end
            if (cnt_nxt == CW'(tfd_pkg::PAYLOAD_BYTES)) begin
              phase_r <= PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          if (in_take) begin
            if (sum_bad) begin
              phase_r      <= PH_SYNC_HI;
              out_idx_r    <= '0;
              out_value_r  <= '0;
              out_status_r <= tfd_pkg::ST_BAD_SUM;
              out_last_r   <= 1'b1;
            end else begin
              phase_r   <= PH_PLAYBACK;
              rd_idx_r  <= '0;
              rd_pend_r <= 1'b0;
            end
          end
        end
        PH_PLAYBACK: begin
          // issue a read
          if (rd_issue) begin
            rd_pend_r  <= 1'b1;
            pend_idx_r <= rd_idx_r[AW-1:0];
            rd_idx_r   <= rd_idx_r + (AW + 1)'(1);
          end
          // read data returns into the (now empty) output slot
          if (rd_pend_r) begin
            rd_pend_r    <= 1'b0;
            out_idx_r    <= pend_idx_r;
            out_value_r  <= ram_q;
            out_status_r <= tfd_pkg::ST_GOOD;
            out_last_r   <= (pend_idx_r == tfd_pkg::LAST_WORD);
            if (pend_idx_r == tfd_pkg::LAST_WORD) begin
              phase_r <= PH_SYNC_HI;
            end
          end
        end
        default: begin
          if (in_take) begin
            phase_r <= (in_rx_byte == sync_r[15:8]) ? PH_SYNC_LO : PH_SYNC_HI;
          end
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_index = 4'(out_idx_r);
  assign out_field_value = out_value_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

### hdl/tfd_checker.sv
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks on the deframer's field output, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_field_index,
  input logic [15:0] out_field_value,
  input logic [1:0]  out_status,
  input logic        out_last
);

  localparam logic [3:0] LAST_IDX = 4'(tfd_pkg::NUM_WORDS - 1);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_value) &&
    $stable(out_field_index) && $stable(out_status) && $stable(out_last))
    else $error("output item changed under stall");

  // error items are single, zeroed and final
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tfd_pkg::ST_BAD_LEN ||
                  out_status == tfd_pkg::ST_BAD_SUM) |->
    out_last && out_field_index == '0 && out_field_value == '0)
    else $error("malformed error item");

  // good fields close on the last word
  a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tfd_pkg::ST_GOOD |->
    (out_last == (out_field_index == LAST_IDX)) && out_field_index <= LAST_IDX)
    else $error("good field index or last flag wrong");

  // mode field has an empty high byte
  a_mode_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tfd_pkg::ST_GOOD && out_field_index == '0 |->
    out_field_value[15:8] == 8'h00)
    else $error("mode field high byte not zero");

endmodule

bind telemetry_frame_deframer tfd_checker u_tfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_field_index (out_field_index),
  .out_field_value (out_field_value),
  .out_status      (out_status),
  .out_last        (out_last)
);

### dv/telemetry_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_tb
// Feeds byte streams of sync words, length bytes, payloads and checksums
// under several sync word settings, with random gaps and output stalls, and
// compares every field item with a cycle-free model of the deframer.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_PHASE  = 2;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 40;
  localparam int DIR_ROWS    = 19;

  // one decoded field as the block should deliver it
  typedef struct packed {
    logic [3:0]        index;
    logic [15:0]       value;
    tfd_pkg::status_t  status;
    logic              last;
  } field_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [7:0]        b;
    logic              typed;
    logic [1:0]        n;
    tfd_pkg::status_t  st;
  } row_t;

  typedef enum logic [2:0] {
    HUNT_HI, HUNT_LO, GET_LEN, GET_PAYLOAD, GET_SUM
  } link_phase_t;

  typedef enum int {
    SEQ_GOOD, SEQ_BAD_SUM, SEQ_BAD_LEN, SEQ_BAD_SYNC, SEQ_NOISE
  } seq_kind_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en     = 1'b0;
  logic [15:0] cfg_sync_word = 16'h0000;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte    = 8'h00;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [3:0]  out_field_index;
  logic [15:0] out_field_value;
  logic [1:0]  out_status;
  logic        out_last;

  // deframer model state
  link_phase_t link_phase = HUNT_HI;
  logic [15:0] sync_cfg   = tfd_pkg::SYNC_RESET;
  logic [7:0]  frame_sum  = 8'h00;
  int          pay_cnt    = 0;
  logic [7:0]  pay_mem [tfd_pkg::PAYLOAD_BYTES];

  field_t pending_fields [$];
  int     errors     = 0;
  int     sent_cnt   = 0;
  int     phase_no   = 0;
  int     send_quiet = 0;
  int     stall_quiet = 0;

  // expectation override for the directed rows
  logic              row_typed = 1'b0;
  logic [1:0]        row_n     = 2'd0;
  tfd_pkg::status_t  row_st    = tfd_pkg::ST_GOOD;

  row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b0, 2'd0, tfd_pkg::ST_GOOD},    // noise while hunting
    '{8'hFF, 1'b0, 2'd0, tfd_pkg::ST_GOOD},
    '{8'hEF, 1'b1, 2'd0, tfd_pkg::ST_GOOD},    // first sync byte
    '{8'hEF, 1'b1, 2'd0, tfd_pkg::ST_GOOD},    // wrong second byte, not retried as first
    '{8'hFE, 1'b1, 2'd0, tfd_pkg::ST_GOOD},    // stray low byte while hunting
    '{8'hEF, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'hFE, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'h00, 1'b1, 2'd1, tfd_pkg::ST_BAD_LEN}, // zero length
    '{8'hEF, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'hFE, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'hFF, 1'b1, 2'd1, tfd_pkg::ST_BAD_LEN}, // all-ones length
    '{8'hEF, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'hFE, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'h18, 1'b1, 2'd1, tfd_pkg::ST_BAD_LEN}, // one short
    '{8'hEF, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'hFE, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'h1A, 1'b1, 2'd1, tfd_pkg::ST_BAD_LEN}, // one long
    '{8'hEF, 1'b1, 2'd0, tfd_pkg::ST_GOOD},
    '{8'h00, 1'b1, 2'd0, tfd_pkg::ST_GOOD}     // wrong second byte
  };

  telemetry_frame_deframer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_sync_word   (cfg_sync_word),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  // clock and reset
  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // deframer model: advance by one byte, return the fields it releases
  function automatic void deframe_byte(input logic [7:0] b, output int n,
                                       output field_t res [tfd_pkg::NUM_WORDS]);
    logic [7:0] neg;
    n = 0;
    case (link_phase)
      HUNT_LO: link_phase = (b == sync_cfg[7:0]) ? GET_LEN : HUNT_HI;
      GET_LEN: begin
        if (b != tfd_pkg::LEN_BYTE) begin
          link_phase = HUNT_HI;
          res[0] = '{4'd0, 16'd0, tfd_pkg::ST_BAD_LEN, 1'b1};
          n = 1;
        end else begin
          frame_sum = b;
          pay_cnt = 0;
          link_phase = GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        pay_mem[pay_cnt] = b;
        frame_sum = frame_sum + b;
        pay_cnt++;
        if (pay_cnt >= tfd_pkg::PAYLOAD_BYTES) link_phase = GET_SUM;
      end
      GET_SUM: begin
        link_phase = HUNT_HI;
        neg = 8'd0 - frame_sum;
        if (neg != b) begin
          res[0] = '{4'd0, 16'd0, tfd_pkg::ST_BAD_SUM, 1'b1};
          n = 1;
        end else begin
          // mode byte, then little-endian words
          res[0] = '{4'd0, {8'h00, pay_mem[0]}, tfd_pkg::ST_GOOD, 1'b0};
          for (int k = 1; k < tfd_pkg::NUM_WORDS; k++) begin
            res[k] = '{4'(k), {pay_mem[2*k], pay_mem[2*k-1]}, tfd_pkg::ST_GOOD,
                       logic'(k == tfd_pkg::NUM_WORDS - 1)};
          end
          n = tfd_pkg::NUM_WORDS;
        end
      end
      default: link_phase = (b == sync_cfg[15:8]) ? HUNT_LO : HUNT_HI;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // accepted bytes feed the model; accepted fields are checked in order
  always @(posedge clk) begin
    int     n;
    field_t res [tfd_pkg::NUM_WORDS];
    field_t want;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      deframe_byte(in_rx_byte, n, res);
      if (row_typed) begin
        n = int'(row_n);
        res[0] = '{4'd0, 16'd0, row_st, 1'b1};
      end
      for (int i = 0; i < n; i++) pending_fields.push_back(res[i]);
    end
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_fields.size() == 0) begin
        report_mismatch("field item with none expected", out_field_value, 16'h0);
      end else begin
        want = pending_fields.pop_front();
        if (out_field_index !== want.index)
          report_mismatch("field_index", 16'(out_field_index), 16'(want.index));
        if (out_field_value !== want.value)
          report_mismatch("field_value", out_field_value, want.value);
        if (out_status !== want.status)
          report_mismatch("status", 16'(out_status), 16'(want.status));
        if (out_last !== want.last)
          report_mismatch("last", 16'(out_last), 16'(want.last));
      end
    end
  end

  // idle length: mostly none, some short, a few long, with quiet runs
  function automatic int idle_len(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output stall: random, plus one long hold while the sender keeps going
  initial begin
    bit held;
    int len;
    held = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (phase_no == HOLD_PHASE && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        len = idle_len(stall_quiet);
        out_stall <= (len > 0);
        repeat ((len > 0) ? len : 1) @(negedge clk);
      end
    end
  end

  // present one byte after a random gap and wait for it to be taken;
  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_cnt++;
    @(negedge clk);
  endtask

  // hold off the sender until every expected field has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_fields.size() != 0);
  endtask

  task automatic write_sync(input logic [15:0] w);
    wait_drain();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_sync_word <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sync_cfg = w;
  endtask

  function automatic seq_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return SEQ_GOOD;
    if (r < 70) return SEQ_BAD_SUM;
    if (r < 80) return SEQ_BAD_LEN;
    if (r < 90) return SEQ_BAD_SYNC;
    return SEQ_NOISE;
  endfunction

  // one byte sequence of the given kind, framed with the current sync word
  task automatic send_seq(input seq_kind_t kind);
    logic [7:0] body [tfd_pkg::PAYLOAD_BYTES];
    logic [7:0] acc;
    logic [7:0] b;
    int         mode;
    mode = $urandom_range(0, 7);
    acc = tfd_pkg::LEN_BYTE;
    foreach (body[i]) begin
      body[i] = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom);
      acc = acc + body[i];
    end
    if (kind == SEQ_NOISE) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else begin
      send_byte(sync_cfg[15:8]);
      if (kind == SEQ_BAD_SYNC) begin
        do b = 8'($urandom); while (b == sync_cfg[7:0]);
        send_byte(b);
      end else begin
        send_byte(sync_cfg[7:0]);
        if (kind == SEQ_BAD_LEN) begin
          case ($urandom_range(0, 4))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = tfd_pkg::LEN_BYTE - 8'd1;
            3: b = tfd_pkg::LEN_BYTE + 8'd1;
            default: do b = 8'($urandom); while (b == tfd_pkg::LEN_BYTE);
          endcase
          send_byte(b);
        end else begin
          send_byte(tfd_pkg::LEN_BYTE);
          foreach (body[i]) send_byte(body[i]);
          b = 8'd0 - acc;
          if (kind == SEQ_BAD_SUM) b = b + 8'($urandom_range(1, 255));
          send_byte(b);
        end
      end
    end
  endtask

  // main stimulus
  initial begin
    logic [15:0] sync_plan [6];
    int          target;
    sync_plan = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h1919, tfd_pkg::SYNC_RESET,
                  16'($urandom)};
    @(posedge rst_n);
    @(negedge clk);

    // directed rows under the reset sync word
    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_n     = dir_rows[i].n;
      row_st    = dir_rows[i].st;
      send_byte(dir_rows[i].b);
    end
    row_typed = 1'b0;

    // random frames, first under the reset sync word, then the others
    send_seq(SEQ_GOOD);
    send_seq(SEQ_BAD_SUM);
    while (sent_cnt < 45) send_seq(pick_kind());
    for (int p = 1; p <= 6; p++) begin
      write_sync(sync_plan[p-1]);
      phase_no = p;
      target = sent_cnt + 15;
      if (p == HOLD_PHASE) begin
        // back-to-back frames into a stalled output
        send_quiet = 80;
        send_seq(SEQ_GOOD);
        send_seq(SEQ_GOOD);
      end
      while (sent_cnt < target) send_seq(pick_kind());
    end

    wait_drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0)
      $display("telemetry_frame_deframer: match");
    else
      $display("telemetry_frame_deframer: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("telemetry_frame_deframer: mismatch");
    $finish;
  end

endmodule
